[rtl/cck_pkg.sv]
// Shared types and constants for the color-key sprite blitter.
// Used by every module of the block; depends on nothing else.
package cck_pkg;

    localparam int MAX_SIDE   = 128;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int AREA_W     = 2 * SIDE_W;
    localparam int COORD_W    = 16;
    localparam int DIM_W      = 8;
    localparam int COLOUR_W   = 16;
    localparam int ADDR_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Sprite-relative coordinates: object minus view plus half a side.
    localparam int REL_W   = 18;
    localparam int B_W     = REL_W + 1;
    localparam int A_W     = (REL_W + 1 > DIM_W + SIDE_W + 1) ? REL_W + 1 : DIM_W + SIDE_W + 1;
    localparam int START_W = A_W + SIDE_W + 2;
    localparam int POS_W   = START_W + 2;
    localparam int X_W     = B_W + 1;

    localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'((MAX_SIDE < 128) ? MAX_SIDE : 128);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_X = 2'd0,
        REG_VIEW_Y = 2'd1,
        REG_SIDE   = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ACT_BEGIN = 1'b0,
        ACT_PIXEL = 1'b1
    } t_action;

    typedef struct packed {
        logic signed [COORD_W-1:0] view_x;
        logic signed [COORD_W-1:0] view_y;
        logic [SIDE_W-1:0]         side;
        logic [AREA_W-1:0]         area;
    } t_cfg;

    // Request held between the counter stage and the placement stage.
    // Begin: a = first row minus half height, b = first column minus half width.
    // Pixel: a = row times side, b = column.
    typedef struct packed {
        logic                  is_begin;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic [COLOUR_W-1:0]   colour;
    } t_s1;

endpackage

[rtl/cck_cfg.sv]
// Configuration registers of the sprite blitter: view center and buffer side.
// Depends on cck_pkg; the side is saturated and its square kept ready.
module cck_cfg
    import cck_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic [SIDE_W-1:0]  sat_side;

    always_comb begin
        if (int'(i_cfg_data[7:0]) > MAX_SIDE) begin
            sat_side = SIDE_W'(MAX_SIDE);
        end else begin
            sat_side = SIDE_W'(i_cfg_data[7:0]);
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_VIEW_X: begin
                    n_cfg.view_x = i_cfg_data;
                end
                REG_VIEW_Y: begin
                    n_cfg.view_y = i_cfg_data;
                end
                REG_SIDE: begin
                    n_cfg.side = sat_side;
                    n_cfg.area = AREA_W'(sat_side) * AREA_W'(sat_side);
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_x <= '0;
            r_cfg.view_y <= '0;
            r_cfg.side   <= SIDE_RST;
            r_cfg.area   <= AREA_W'(SIDE_RST) * AREA_W'(SIDE_RST);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/cck_seq.sv]
// Input stage: sprite row and column counters and the first pipeline register.
// Depends on cck_pkg; feeds cck_place with one request per useful item.
module cck_seq
    import cck_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic signed [COORD_W-1:0]  i_obj_x,
    input  logic signed [COORD_W-1:0]  i_obj_y,
    input  logic [DIM_W-1:0]           i_sprite_width,
    input  logic [DIM_W-1:0]           i_sprite_height,
    input  logic [COLOUR_W-1:0]        i_pixel_colour,
    input  logic                       i_adv,
    output logic                       o_s1_valid,
    output t_s1                        o_s1
);

    logic [DIM_W-1:0]       r_row, n_row;
    logic [DIM_W-1:0]       r_col, n_col;
    logic [DIM_W-1:0]       r_held_w, n_held_w;
    logic [DIM_W-1:0]       r_held_h, n_held_h;
    logic                   r_active, n_active;
    logic                   r_s1_valid, n_s1_valid;
    t_s1                    r_s1, n_s1;
    logic                   accept;
    logic [SIDE_W-1:0]      half_side;
    logic signed [B_W-1:0]  colv;
    logic signed [B_W-1:0]  rowv;
    logic [DIM_W+SIDE_W-1:0] row_off;
    logic [DIM_W:0]         col_next;
    logic [DIM_W:0]         row_next;

    assign o_in_stall = r_s1_valid && !i_adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign half_side = i_cfg.side >> 1;
    assign colv = B_W'(i_obj_x) - B_W'(i_cfg.view_x) + B_W'(half_side)
                - B_W'(i_sprite_width >> 1);
    assign rowv = B_W'(i_obj_y) - B_W'(i_cfg.view_y) + B_W'(half_side)
                - B_W'(i_sprite_height >> 1);
    assign row_off  = r_row * i_cfg.side;
    assign col_next = {1'b0, r_col} + 1'b1;
    assign row_next = {1'b0, r_row} + 1'b1;

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_held_w   = r_held_w;
        n_held_h   = r_held_h;
        n_active   = r_active;
        n_s1_valid = r_s1_valid && !i_adv;
        n_s1       = r_s1;
        if (!o_in_stall) begin
            n_s1_valid = 1'b0;
        end
        if (accept) begin
            if (t_action'(i_action) == ACT_BEGIN) begin
                n_held_w    = i_sprite_width;
                n_held_h    = i_sprite_height;
                n_row       = '0;
                n_col       = '0;
                n_active    = (i_sprite_width != '0) && (i_sprite_height != '0);
                n_s1_valid  = 1'b1;
                n_s1.is_begin = 1'b1;
                n_s1.a      = A_W'(rowv);
                n_s1.b      = colv;
                n_s1.colour = i_pixel_colour;
            end else if (r_active) begin
                // Row-major walk; the sprite ends after its last column of its last row.
                if (col_next >= {1'b0, r_held_w}) begin
                    n_col = '0;
                    n_row = row_next[DIM_W-1:0];
                    if (row_next >= {1'b0, r_held_h}) begin
                        n_active = 1'b0;
                    end
                end else begin
                    n_col = col_next[DIM_W-1:0];
                end
                // Transparent pixels only move the counters.
                if (i_pixel_colour != '0) begin
                    n_s1_valid    = 1'b1;
                    n_s1.is_begin = 1'b0;
                    n_s1.a        = A_W'(row_off);
                    n_s1.b        = B_W'(r_col);
                    n_s1.colour   = i_pixel_colour;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_held_w   <= '0;
            r_held_h   <= '0;
            r_active   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_held_w   <= n_held_w;
            r_held_h   <= n_held_h;
            r_active   <= n_active;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_col < r_held_w))
        else $error("column counter ran past the sprite width");

    a_row_in_sprite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_row < r_held_h))
        else $error("row counter ran past the sprite height");

    a_pixel_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.is_begin) |-> (r_s1.colour != '0))
        else $error("transparent pixel entered the pipeline");

endmodule

[rtl/cck_place.sv]
// Placement stage: sprite start address, buffer address and clipping, result register.
// Depends on cck_pkg; takes requests from cck_seq.
module cck_place
    import cck_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_s1_valid,
    input  t_s1                  i_s1,
    output logic                 o_adv,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ADDR_W-1:0]    o_buffer_address,
    output logic [COLOUR_W-1:0]  o_write_colour
);

    logic signed [START_W-1:0]     r_start, n_start;
    logic signed [B_W-1:0]         r_colv, n_colv;
    logic                          r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]             r_addr, n_addr;
    logic [COLOUR_W-1:0]           r_colour, n_colour;
    logic signed [A_W+SIDE_W:0]    start_prod;
    logic signed [POS_W-1:0]       pos;
    logic signed [X_W-1:0]         x_pos;
    logic signed [SIDE_W:0]        side_s;
    logic                          out_ready;
    logic                          hit;

    assign side_s     = $signed({1'b0, i_cfg.side});
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign o_adv      = i_s1_valid && out_ready;

    assign start_prod = i_s1.a * side_s;
    assign pos   = POS_W'(r_start) + POS_W'(i_s1.a) + POS_W'(i_s1.b);
    assign x_pos = X_W'(r_colv) + X_W'(i_s1.b);

    // Columns outside the buffer are clipped; rows fall out through the address range.
    assign hit = !pos[POS_W-1]
              && (pos < POS_W'($signed({1'b0, i_cfg.area})))
              && !x_pos[X_W-1]
              && (x_pos < X_W'(side_s));

    always_comb begin
        n_start     = r_start;
        n_colv      = r_colv;
        n_out_valid = r_out_valid && i_out_stall;
        n_addr      = r_addr;
        n_colour    = r_colour;
        if (o_adv) begin
            if (i_s1.is_begin) begin
                n_start = START_W'(start_prod) + START_W'(i_s1.b);
                n_colv  = i_s1.b;
            end else if (hit) begin
                n_out_valid = 1'b1;
                n_addr      = pos[ADDR_W-1:0];
                n_colour    = i_s1.colour;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_colv      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start     <= n_start;
            r_colv      <= n_colv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_colour <= n_colour;
    end

    assign o_out_valid      = r_out_valid;
    assign o_buffer_address = r_addr;
    assign o_write_colour   = r_colour;

    a_write_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_colour != '0))
        else $error("transparent color reached the write port");

    a_begin_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && i_s1.is_begin && !r_out_valid) |=> !r_out_valid)
        else $error("sprite begin produced a buffer write");

    a_begin_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && i_s1.is_begin) |=> (r_colv == $past(i_s1.b)))
        else $error("sprite origin column not taken at begin");

endmodule

[rtl/clipped_color_key_sprite_blit_core.sv]
// A pixel request that is accepted is registered in the counter stage, its write in the
// placement stage, which puts it on the write port. Throughput: one request per cycle, begin
// or pixel; the counter stage and the placement stage each hold one request and both advance
// whenever the write port is free. Transparent, clipped and surplus pixels produce no write.
// Reset is synchronous, active low: view at zero, side 128, no sprite in progress, pipeline empty.
module clipped_color_key_sprite_blit_core
    import cck_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic signed [COORD_W-1:0]  i_obj_x,
    input  logic signed [COORD_W-1:0]  i_obj_y,
    input  logic [DIM_W-1:0]           i_sprite_width,
    input  logic [DIM_W-1:0]           i_sprite_height,
    input  logic [COLOUR_W-1:0]        i_pixel_colour,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ADDR_W-1:0]          o_buffer_address,
    output logic [COLOUR_W-1:0]        o_write_colour
);

    t_cfg  cfg;
    t_s1   s1;
    logic  s1_valid;
    logic  adv;

    cck_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cck_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_obj_x         (i_obj_x),
        .i_obj_y         (i_obj_y),
        .i_sprite_width  (i_sprite_width),
        .i_sprite_height (i_sprite_height),
        .i_pixel_colour  (i_pixel_colour),
        .i_adv           (adv),
        .o_s1_valid      (s1_valid),
        .o_s1            (s1)
    );

    cck_place u_place (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_s1_valid       (s1_valid),
        .i_s1             (s1),
        .o_adv            (adv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_buffer_address (o_buffer_address),
        .o_write_colour   (o_write_colour)
    );

endmodule

[verif/blit_scoreboard_pkg.sv]
// Scoreboard for the sprite blitter testbench: request and buffer-write types and a
// class that predicts buffer writes from accepted requests and checks the block's output.
// Depends on cck_pkg for widths and codes.
package blit_scoreboard_pkg;
    import cck_pkg::*;

    typedef struct {
        t_action                   action;
        logic signed [COORD_W-1:0] obj_x;
        logic signed [COORD_W-1:0] obj_y;
        logic [DIM_W-1:0]          sprite_width;
        logic [DIM_W-1:0]          sprite_height;
        logic [COLOUR_W-1:0]       pixel_colour;
    } blit_request_t;

    typedef struct {
        logic [ADDR_W-1:0]   buffer_address;
        logic [COLOUR_W-1:0] write_colour;
    } buffer_write_t;

    class blit_scoreboard;
        logic signed [COORD_W-1:0] view_x;
        logic signed [COORD_W-1:0] view_y;
        logic [7:0]                side_setting;

        int     row_count;
        int     col_count;
        int     held_width;
        int     held_height;
        longint start_address;
        longint relative_x;
        bit     active;

        buffer_write_t expected_writes[$];
        int            mismatch_count;

        function new();
            view_x         = '0;
            view_y         = '0;
            side_setting   = 8'd128;
            row_count      = 0;
            col_count      = 0;
            held_width     = 0;
            held_height    = 0;
            start_address  = 0;
            relative_x     = 0;
            active         = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        function void note_config(t_cfg_reg index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_VIEW_X: view_x = data;
                REG_VIEW_Y: view_y = data;
                REG_SIDE:   side_setting = data[7:0];
                default: ;
            endcase
        endfunction

        function longint buffer_side();
            return (side_setting > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(side_setting);
        endfunction

        // Updates the sprite state for one accepted request and queues the write it causes.
        function void note_request(blit_request_t req);
            longint        side;
            longint        rel_y;
            longint        row;
            longint        col;
            longint        half_w;
            longint        pos;
            buffer_write_t write;
            side = buffer_side();
            if (req.action == ACT_BEGIN) begin
                held_width    = int'(req.sprite_width);
                held_height   = int'(req.sprite_height);
                relative_x    = longint'(req.obj_x) - longint'(view_x) + side / 2;
                rel_y         = longint'(req.obj_y) - longint'(view_y) + side / 2;
                start_address = (rel_y - longint'(held_height / 2)) * side
                              + (relative_x - longint'(held_width / 2));
                row_count     = 0;
                col_count     = 0;
                active        = (held_width != 0) && (held_height != 0);
                return;
            end
            if (!active)
                return;
            row    = row_count;
            col    = col_count;
            half_w = held_width / 2;
            pos    = start_address + row * side + col;

            col_count++;
            if (col_count >= held_width) begin
                col_count = 0;
                row_count++;
                if (row_count >= held_height)
                    active = 1'b0;
            end

            // Rows falling off the top or bottom show up as an address outside the buffer.
            if (pos >= 0 && pos < side * side && col >= half_w - relative_x
                    && col < side + half_w - relative_x && req.pixel_colour != '0) begin
                write.buffer_address = ADDR_W'(pos);
                write.write_colour   = req.pixel_colour;
                expected_writes.push_back(write);
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_write(logic [ADDR_W-1:0] address, logic [COLOUR_W-1:0] colour);
            buffer_write_t want;
            if (expected_writes.size() == 0) begin
                report($sformatf("write to %0d colour %h with none predicted", address, colour));
                return;
            end
            want = expected_writes.pop_front();
            if (address !== want.buffer_address)
                report($sformatf("buffer_address %0d, predicted %0d",
                                 address, want.buffer_address));
            if (colour !== want.write_colour)
                report($sformatf("write_colour %h, predicted %h", colour, want.write_colour));
        endtask
    endclass

endpackage

[verif/testbench.sv]
// Top-level testbench for clipped_color_key_sprite_blit_core: directed sprites, then
// phases of random sprites under varied view and side settings with random stalls.
// Depends on cck_pkg, blit_scoreboard_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cck_pkg::*;
    import blit_scoreboard_pkg::*;

    localparam int REQUEST_COUNT = 450;
    localparam int FLUSH_CYCLES  = 4;
    localparam int TIMEOUT_NS    = 20_000_000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_action;
    logic signed [COORD_W-1:0] i_obj_x;
    logic signed [COORD_W-1:0] i_obj_y;
    logic [DIM_W-1:0]          i_sprite_width;
    logic [DIM_W-1:0]          i_sprite_height;
    logic [COLOUR_W-1:0]       i_pixel_colour;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [ADDR_W-1:0]         o_buffer_address;
    logic [COLOUR_W-1:0]       o_write_colour;

    blit_scoreboard board = new();
    int             sent = 0;
    bit             calm = 1'b0;
    int             side_menu [13] = '{0, 1, 2, 3, 7, 16, 33, 64, 100, 127, 128, 129, 255};

    clipped_color_key_sprite_blit_core i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones and a rare long one; none during a calm phase.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic blit_request_t random_request();
        blit_request_t req;
        req.action        = t_action'($urandom_range(0, 1));
        req.obj_x         = COORD_W'($urandom);
        req.obj_y         = COORD_W'($urandom);
        req.sprite_width  = DIM_W'($urandom);
        req.sprite_height = DIM_W'($urandom);
        req.pixel_colour  = COLOUR_W'($urandom);
        return req;
    endfunction

    function automatic logic [COLOUR_W-1:0] random_colour();
        if ($urandom_range(0, 99) < 25)
            return '0;
        return COLOUR_W'($urandom_range(1, 65535));
    endfunction

    task automatic send_request(blit_request_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= req.action;
        i_obj_x         <= req.obj_x;
        i_obj_y         <= req.obj_y;
        i_sprite_width  <= req.sprite_width;
        i_sprite_height <= req.sprite_height;
        i_pixel_colour  <= req.pixel_colour;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req);
        sent++;
    endtask

    task automatic send_begin(int ox, int oy, int w, int h);
        blit_request_t req;
        req               = random_request();
        req.action        = ACT_BEGIN;
        req.obj_x         = COORD_W'(ox);
        req.obj_y         = COORD_W'(oy);
        req.sprite_width  = DIM_W'(w);
        req.sprite_height = DIM_W'(h);
        send_request(req);
    endtask

    task automatic send_pixel(logic [COLOUR_W-1:0] colour);
        blit_request_t req;
        req              = random_request();
        req.action       = ACT_PIXEL;
        req.pixel_colour = colour;
        send_request(req);
    endtask

    // Pixels that produce no write may still sit in the pipeline, hence the extra cycles.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] vx_data, logic [CFG_DATA_W-1:0] vy_data,
                             logic [CFG_DATA_W-1:0] side_data);
        logic [CFG_DATA_W-1:0] values [3];
        t_cfg_reg              index;
        values = '{vx_data, vy_data, side_data};
        wait_idle();
        for (int k = 0; k < 3; k++) begin
            index = t_cfg_reg'(k);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= index;
            i_cfg_data  <= values[k];
            @(posedge i_clk);
            board.note_config(index, values[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_write(o_buffer_address, o_write_colour);
    end

    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int                        stop_at;
        int                        phase_end;
        int                        phase;
        int                        roll;
        int                        w;
        int                        h;
        int                        s;
        int                        count;
        int                        relx;
        int                        rely;
        logic [7:0]                side_byte;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_VIEW_X;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_BEGIN;
        i_obj_x         <= '0;
        i_obj_y         <= '0;
        i_sprite_width  <= '0;
        i_sprite_height <= '0;
        i_pixel_colour  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset view and side.
        send_pixel(16'hFFFF);
        send_begin(0, 0, 2, 2);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8001);
        send_pixel(16'h7FFE);
        send_pixel(16'hABCD);
        send_begin(0, 0, 0, 5);
        send_pixel(16'h5555);
        // Largest sprite far outside the buffer, abandoned after one pixel.
        send_begin(-32768, 32767, 255, 255);
        send_pixel(16'h0001);
        // Two left columns cut off, second row below the buffer.
        send_begin(-64, 64, 4, 2);
        repeat (8) send_pixel(COLOUR_W'($urandom_range(1, 65535)));
        // Side shrinks to 16 after two of the six pixels of a sprite at the top edge of the buffer.
        send_begin(-62, -63, 3, 2);
        send_pixel(16'h00FF);
        send_pixel(16'hFF00);
        configure(16'h0000, 16'h0000, 16'h0010);
        repeat (4) send_pixel(COLOUR_W'($urandom_range(1, 65535)));

        stop_at = sent + REQUEST_COUNT;
        phase   = 0;
        while (sent < stop_at) begin
            case (phase)
                0: begin
                    vx = 16'sh7FFF;
                    vy = 16'sh8000;
                    side_byte = 8'd255;
                end
                1: begin
                    vx = 16'sh8000;
                    vy = 16'sh7FFF;
                    side_byte = 8'd1;
                end
                2: begin
                    vx = '0;
                    vy = '0;
                    side_byte = 8'd0;
                end
                3: begin
                    vx = COORD_W'($urandom);
                    vy = COORD_W'($urandom);
                    side_byte = 8'd128;
                end
                default: begin
                    roll = $urandom_range(0, 99);
                    vx = (roll < 30) ? '0 : COORD_W'($urandom);
                    vy = (roll < 30) ? '0 : COORD_W'($urandom);
                    side_byte = 8'(side_menu[$urandom_range(0, 12)]);
                end
            endcase
            configure(vx, vy, {8'($urandom), side_byte});
            s         = (side_byte > 8'd128) ? 128 : int'(side_byte);
            calm      = ($urandom_range(0, 3) == 0);
            phase_end = sent + $urandom_range(30, 60);

            while (sent < phase_end && sent < stop_at) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    send_request(random_request());
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 80) begin
                        w = $urandom_range(1, 8);
                        h = $urandom_range(1, 8);
                    end else if (roll < 95) begin
                        w = $urandom_range(1, 24);
                        h = $urandom_range(1, 6);
                    end else if (roll < 98) begin
                        w = ($urandom_range(0, 1) == 0) ? 255 : 1;
                        h = (w == 255) ? 1 : 255;
                    end else begin
                        w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
                        h = (w == 0) ? $urandom_range(0, 3) : 0;
                    end
                    // Centre so that the sprite mostly overlaps the buffer, edges included.
                    relx = $urandom_range(0, s + w + 8) - (w / 2 + 4);
                    rely = $urandom_range(0, s + h + 8) - (h / 2 + 4);
                    count = w * h;
                    roll = $urandom_range(0, 99);
                    if (roll < 13 && count > 0)
                        count = $urandom_range(0, count - 1);
                    else if (roll < 26)
                        count += $urandom_range(1, 3);
                    send_begin(int'(vx) + relx - s / 2, int'(vy) + rely - s / 2, w, h);
                    repeat (count) send_pixel(random_colour());
                end
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
            end
            phase++;
        end

        calm = 1'b0;
        wait_idle();
        repeat (FLUSH_CYCLES * 4) @(posedge i_clk);
        if (board.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
